// ===== sv/h2r_pkg.sv =====
// ----------------------------------------------------------------------------
// h2r_pkg : shared types and constants for the hsv to rgb converter
// Payload structs for the request and response channels, hue sector codes
// and the small modulo-3 helper used by the hue wrap.
// ----------------------------------------------------------------------------
package h2r_pkg;

   // default fraction bits of saturation, brightness and the color outputs
   localparam int COMPONENT_FRAC_BITS_DEFAULT = 8;

   // fraction bits of hue within one sector
   localparam int HUE_FRAC_BITS = 8;

   // width of every color component field
   localparam int COMPONENT_WIDTH = 9;

   typedef struct packed {
      logic signed [15:0] hue;
      logic [COMPONENT_WIDTH-1:0] saturation;
      logic [COMPONENT_WIDTH-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [COMPONENT_WIDTH-1:0] red;
      logic [COMPONENT_WIDTH-1:0] green;
      logic [COMPONENT_WIDTH-1:0] blue;
   } rsp_type;

   // hexcone sectors, 60 degrees each
   typedef enum logic [2:0] {
      SEC_RED_TO_YELLOW     = 3'd0,
      SEC_YELLOW_TO_GREEN   = 3'd1,
      SEC_GREEN_TO_CYAN     = 3'd2,
      SEC_CYAN_TO_BLUE      = 3'd3,
      SEC_BLUE_TO_MAGENTA   = 3'd4,
      SEC_MAGENTA_TO_RED    = 3'd5
   } sector_type;

   // x mod 3 by summing base-4 digits (4 is 1 mod 3)
   function automatic logic [1:0] mod3_8(input logic [7:0] x);
      logic [3:0] sum;
      logic [2:0] fold;
      begin
         sum = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
         fold = 3'(sum[1:0]) + 3'(sum[3:2]);
         if (fold >= 3'd6) begin
            fold = fold - 3'd6;
         end else if (fold >= 3'd3) begin
            fold = fold - 3'd3;
         end
         mod3_8 = fold[1:0];
      end
   endfunction

endpackage

// ===== sv/h2r_scale.sv =====
// ----------------------------------------------------------------------------
// h2r_scale : registered brightness scaling
// Forms (brightness * (one - frac)) >> F with truncation and registers it.
// ----------------------------------------------------------------------------
module h2r_scale #(
   parameter int COMPONENT_FRAC_BITS = h2r_pkg::COMPONENT_FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic [h2r_pkg::COMPONENT_WIDTH-1:0] brightness_in,
   input  logic [h2r_pkg::COMPONENT_WIDTH-1:0] frac_in,
   output logic [h2r_pkg::COMPONENT_WIDTH-1:0] scaled_out
);

   localparam int F  = COMPONENT_FRAC_BITS;
   localparam int CW = h2r_pkg::COMPONENT_WIDTH;
   localparam int XW = (F + 1 > CW) ? F + 1 : CW;
   localparam int PW = F + 1 + CW;

   logic [F:0]    one_c;
   logic [XW-1:0] frac_w;
   logic [F:0]    diff;
   logic [PW-1:0] prod;
   logic [CW-1:0] scaled_in;
   logic [CW-1:0] scaled_ff;

   // frac never exceeds one, so the resize to F+1 bits loses nothing
   assign one_c     = {1'b1, {F{1'b0}}};
   assign frac_w    = XW'(frac_in);
   assign diff      = one_c - frac_w[F:0];
   assign prod      = PW'(brightness_in) * PW'(diff);
   assign scaled_in = prod[F+CW-1:F];

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

   assign scaled_out = scaled_ff;

endmodule

// ===== sv/hsv_to_rgb_pixel_converter_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_core : pipelined hsv to rgb pixel converter
// Converts one hsv pixel to rgb every clock through a four-stage pipeline.
// ----------------------------------------------------------------------------
// A pixel transfer happens on any clock where start is high and busy is low.
// busy is low at all times except while reset is held, so a new pixel can be
// sent every cycle. Each result runs through the register stages below, with
// rsp_valid high for exactly one cycle, in request order; the receiver must
// take it in that cycle because nothing holds results back. Operand
// conditioning, the saturation-by-fraction products, the brightness
// products and the final sector select each own a register stage, in
// that order. Hue is wrapped to one full turn (1536 counts of 60/256
// degree), saturation and brightness above one are clamped to one, and zero
// saturation comes out gray because p, q and t all collapse to brightness.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_converter_core #(
   parameter int COMPONENT_FRAC_BITS = h2r_pkg::COMPONENT_FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  h2r_pkg::req_type req_data,
   output logic             rsp_valid,
   output h2r_pkg::rsp_type rsp_data
);

   localparam int F  = COMPONENT_FRAC_BITS;
   localparam int CW = h2r_pkg::COMPONENT_WIDTH;
   localparam int HF = h2r_pkg::HUE_FRAC_BITS;
   localparam int KW = (F + 1 > CW) ? F + 1 : CW;
   localparam logic [KW-1:0] ONE_W = KW'(1) << F;

   // ---------------------------------------------------------------- stage 1
   // hue wrap: hue = 512 * hi + lo with hi = floor(hue / 512), so
   // hue mod 1536 = 512 * (hi mod 3) + lo; hi + 66 keeps the mod 3 positive
   logic                  accept;
   logic [7:0]            hi_bias;
   logic [1:0]            hi_mod3;
   logic [KW-1:0]         sat_w;
   logic [KW-1:0]         bri_w;
   logic [KW-1:0]         sat_clamp;
   logic [KW-1:0]         bri_clamp;

   logic                  valid1_ff;
   logic [CW-1:0]         sat1_ff;
   logic [CW-1:0]         bri1_ff;
   h2r_pkg::sector_type   sector1_ff;
   logic [HF-1:0]         frac1_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   assign hi_bias = {req_data.hue[15], req_data.hue[15:9]} + 8'd66;
   assign hi_mod3 = h2r_pkg::mod3_8(hi_bias);

   // clamp both components to one
   assign sat_w     = KW'(req_data.saturation);
   assign bri_w     = KW'(req_data.brightness);
   assign sat_clamp = (sat_w > ONE_W) ? ONE_W : sat_w;
   assign bri_clamp = (bri_w > ONE_W) ? ONE_W : bri_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      sat1_ff    <= sat_clamp[CW-1:0];
      bri1_ff    <= bri_clamp[CW-1:0];
      // sector = hue mod 1536 >> 8 = 2 * (hi mod 3) + hue bit 8
      sector1_ff <= h2r_pkg::sector_type'({hi_mod3, req_data.hue[8]});
      frac1_ff   <= req_data.hue[HF-1:0];
   end

   // ---------------------------------------------------------------- stage 2
   // saturation times fraction and times its complement, truncated
   logic [CW+HF-1:0]      sf_prod;
   logic [CW+HF:0]        sg_prod;
   logic [HF:0]           frac_comp;

   logic                  valid2_ff;
   logic [CW-1:0]         sat2_ff;
   logic [CW-1:0]         bri2_ff;
   h2r_pkg::sector_type   sector2_ff;
   logic [CW-1:0]         sf2_ff;
   logic [CW-1:0]         sg2_ff;

   assign frac_comp = {1'b1, {HF{1'b0}}} - (HF + 1)'(frac1_ff);
   assign sf_prod   = (CW + HF)'(sat1_ff) * (CW + HF)'(frac1_ff);
   assign sg_prod   = (CW + HF + 1)'(sat1_ff) * (CW + HF + 1)'(frac_comp);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   // both scaled terms stay at or below saturation, so 9 bits hold them
   always_ff @(posedge clock) begin
      sat2_ff    <= sat1_ff;
      bri2_ff    <= bri1_ff;
      sector2_ff <= sector1_ff;
      sf2_ff     <= sf_prod[HF+CW-1:HF];
      sg2_ff     <= sg_prod[HF+CW-1:HF];
   end

   // ---------------------------------------------------------------- stage 3
   // p, q and t: brightness scaled by one minus each term
   logic [CW-1:0]         p3;
   logic [CW-1:0]         q3;
   logic [CW-1:0]         t3;
   logic                  valid3_ff;
   logic [CW-1:0]         bri3_ff;
   h2r_pkg::sector_type   sector3_ff;

   h2r_scale #(
      .COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)
   ) u_scale_p (
      .clock         (clock),
      .brightness_in (bri2_ff),
      .frac_in       (sat2_ff),
      .scaled_out    (p3)
   );

   h2r_scale #(
      .COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)
   ) u_scale_q (
      .clock         (clock),
      .brightness_in (bri2_ff),
      .frac_in       (sf2_ff),
      .scaled_out    (q3)
   );

   h2r_scale #(
      .COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)
   ) u_scale_t (
      .clock         (clock),
      .brightness_in (bri2_ff),
      .frac_in       (sg2_ff),
      .scaled_out    (t3)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      bri3_ff    <= bri2_ff;
      sector3_ff <= sector2_ff;
   end

   // ---------------------------------------------------------------- stage 4
   // hexcone select of red, green and blue by sector
   h2r_pkg::rsp_type      rsp_in;
   h2r_pkg::rsp_type      rsp_ff;
   logic                  rsp_valid_ff;

   always_comb begin
      unique case (sector3_ff)
         h2r_pkg::SEC_RED_TO_YELLOW: begin
            rsp_in = '{red: bri3_ff, green: t3, blue: p3};
         end
         h2r_pkg::SEC_YELLOW_TO_GREEN: begin
            rsp_in = '{red: q3, green: bri3_ff, blue: p3};
         end
         h2r_pkg::SEC_GREEN_TO_CYAN: begin
            rsp_in = '{red: p3, green: bri3_ff, blue: t3};
         end
         h2r_pkg::SEC_CYAN_TO_BLUE: begin
            rsp_in = '{red: p3, green: q3, blue: bri3_ff};
         end
         h2r_pkg::SEC_BLUE_TO_MAGENTA: begin
            rsp_in = '{red: t3, green: p3, blue: bri3_ff};
         end
         default: begin
            rsp_in = '{red: bri3_ff, green: p3, blue: q3};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // response transfer strobe and data
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the hsv to rgb pixel converter
// Drives directed corner pixels, then a long random pixel stream with bursts
// of idle cycles. Every accepted pixel is converted by an independent model
// in the scoreboard, and each strobed rgb result is compared field by field,
// in order, against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FRAC_BITS     = h2r_pkg::COMPONENT_FRAC_BITS_DEFAULT;
   localparam int CW            = h2r_pkg::COMPONENT_WIDTH;
   localparam int HUE_TURN      = 1536;
   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_PIXELS = 1450;
   localparam int CALM_TAIL     = 200;   // last pixels go back to back
   localparam int PIPE_LATENCY  = 4;
   localparam int DRAIN_LIMIT   = 1000;

   // --------------------------------------------------------------------------
   // scoreboard: predicts rgb for each accepted pixel and checks results
   // --------------------------------------------------------------------------
   class pixel_scoreboard;
      h2r_pkg::rsp_type rgb_expected[$];
      int unsigned      error_count;
      int unsigned      pixel_count;
      int unsigned      checked_count;
      int unsigned      gray_count;
      logic [5:0]       sectors_seen;

      function new();
         error_count   = 0;
         pixel_count   = 0;
         checked_count = 0;
         gray_count    = 0;
         sectors_seen  = '0;
      endfunction

      // fixed point hexcone conversion, products truncated
      function h2r_pkg::rsp_type convert_hsv(input h2r_pkg::req_type px,
                                             output h2r_pkg::sector_type sector);
         int               hue_wrapped;
         int unsigned      one, sat, val, frac, sf, sg, p, q, t, r, g, b;
         h2r_pkg::rsp_type rgb;
         one = 1 << FRAC_BITS;
         hue_wrapped = int'($signed(px.hue)) % HUE_TURN;
         if (hue_wrapped < 0) begin
            hue_wrapped += HUE_TURN;
         end
         sat = (px.saturation > one) ? one : int'(px.saturation);
         val = (px.brightness > one) ? one : int'(px.brightness);
         sector = h2r_pkg::sector_type'(hue_wrapped >> h2r_pkg::HUE_FRAC_BITS);
         frac = hue_wrapped & ((1 << h2r_pkg::HUE_FRAC_BITS) - 1);
         sf = (sat * frac) >> h2r_pkg::HUE_FRAC_BITS;
         sg = (sat * ((1 << h2r_pkg::HUE_FRAC_BITS) - frac)) >> h2r_pkg::HUE_FRAC_BITS;
         p = (val * (one - sat)) >> FRAC_BITS;
         q = (val * (one - sf)) >> FRAC_BITS;
         t = (val * (one - sg)) >> FRAC_BITS;
         if (sat == 0) begin
            r = val; g = val; b = val;
         end else begin
            case (sector)
               h2r_pkg::SEC_RED_TO_YELLOW:   begin r = val; g = t;   b = p;   end
               h2r_pkg::SEC_YELLOW_TO_GREEN: begin r = q;   g = val; b = p;   end
               h2r_pkg::SEC_GREEN_TO_CYAN:   begin r = p;   g = val; b = t;   end
               h2r_pkg::SEC_CYAN_TO_BLUE:    begin r = p;   g = q;   b = val; end
               h2r_pkg::SEC_BLUE_TO_MAGENTA: begin r = t;   g = p;   b = val; end
               default:                      begin r = val; g = p;   b = q;   end
            endcase
         end
         rgb.red   = CW'(r);
         rgb.green = CW'(g);
         rgb.blue  = CW'(b);
         return rgb;
      endfunction

      function void note_pixel(input h2r_pkg::req_type px);
         h2r_pkg::sector_type sector;
         rgb_expected.push_back(convert_hsv(px, sector));
         sectors_seen[sector] = 1'b1;
         pixel_count++;
         if (px.saturation == 0) begin
            gray_count++;
         end
      endfunction

      task report_mismatch(input string what);
         error_count++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_pixel(input h2r_pkg::rsp_type got);
         h2r_pkg::rsp_type want;
         if (rgb_expected.size() == 0) begin
            report_mismatch($sformatf("result r=%0d g=%0d b=%0d with no pixel pending",
                                      got.red, got.green, got.blue));
         end else begin
            want = rgb_expected.pop_front();
            checked_count++;
            if (got.red !== want.red) begin
               report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
            end
            if (got.green !== want.green) begin
               report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
            end
            if (got.blue !== want.blue) begin
               report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
            end
         end
      endtask
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and dut
   // --------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   h2r_pkg::req_type req_data = '0;
   logic             rsp_valid;
   h2r_pkg::rsp_type rsp_data;

   pixel_scoreboard rgb_board;

   always #(CLK_HALF) clock = ~clock;

   hsv_to_rgb_pixel_converter_core #(
      .COMPONENT_FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // --------------------------------------------------------------------------
   // monitor: a pixel transfer is start high with busy low at the edge; a
   // result is only valid for the one cycle its strobe is up
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && start === 1'b1 && busy === 1'b0) begin
         rgb_board.note_pixel(req_data);
      end
      if (!reset && rsp_valid === 1'b1) begin
         rgb_board.check_pixel(rsp_data);
      end
   end

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------

   // any bit pattern at all, out of range values included
   function automatic h2r_pkg::req_type any_pixel();
      h2r_pkg::req_type px;
      px.hue        = 16'($urandom);
      px.saturation = CW'($urandom);
      px.brightness = CW'($urandom);
      return px;
   endfunction

   // mostly in range, with hue spanning two turns either side of zero
   function automatic h2r_pkg::req_type typical_pixel();
      h2r_pkg::req_type px;
      int               pick;
      px.hue = 16'($urandom_range(0, 4 * HUE_TURN - 1) - 2 * HUE_TURN);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         px.saturation = '0;
      end else if (pick == 1) begin
         px.saturation = CW'(1 << FRAC_BITS);
      end else begin
         px.saturation = CW'($urandom_range(1, (1 << FRAC_BITS) - 1));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         px.brightness = '0;
      end else if (pick < 3) begin
         px.brightness = CW'(1 << FRAC_BITS);
      end else begin
         px.brightness = CW'($urandom_range(0, 1 << FRAC_BITS));
      end
      return px;
   endfunction

   // hold start low, with junk on the data bus (n >= 1)
   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) begin
         req_data <= any_pixel();
         @(posedge clock);
      end
   endtask

   // present one pixel and wait for the edge that takes it
   task automatic send_pixel(input h2r_pkg::req_type px);
      start    <= 1'b1;
      req_data <= px;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      h2r_pkg::req_type directed_pixels[$];
      h2r_pkg::req_type px;
      bit               idling_on;
      int               drain_cycles;

      rgb_board = new();

      // hue extremes and wrap points, each sector, gray, clamps, bit patterns
      directed_pixels = '{
         '{16'sd0,      9'd256, 9'd256},   // sector start, fraction zero
         '{16'sd255,    9'd256, 9'd256},   // sector end, fraction max
         '{16'sd256,    9'd256, 9'd200},
         '{16'sd600,    9'd128, 9'd256},
         '{16'sd800,    9'd256, 9'd256},
         '{16'sd1100,   9'd200, 9'd180},
         '{16'sd1535,   9'd256, 9'd256},   // last count of the turn
         '{16'sd1536,   9'd256, 9'd256},   // wraps back to zero
         '{-16'sd1,     9'd256, 9'd256},   // negative wraps to the top
         '{-16'sd1536,  9'd100, 9'd100},
         '{16'sh8000,   9'd220, 9'd240},   // most negative hue
         '{16'sh7FFF,   9'd220, 9'd240},   // most positive hue
         '{16'sd300,    9'd0,   9'd256},   // gray
         '{16'sd900,    9'd0,   9'd511},   // gray with brightness clamp
         '{16'sd100,    9'd257, 9'd256},   // saturation just over one
         '{16'sd700,    9'd511, 9'd300},   // both clamped
         '{16'sd400,    9'd256, 9'd0},     // black
         '{16'sd1200,   9'd1,   9'd1},
         '{16'sd1300,   9'd255, 9'd255},
         '{16'shAAAA,   9'h155, 9'h0AA},
         '{16'sh5555,   9'h0AA, 9'h155},
         '{-16'sd3000,  9'd77,  9'd199}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_pixels[i]) begin
         send_pixel(directed_pixels[i]);
      end

      // random stream: idling comes and goes in stretches, none at the end
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         idling_on = (i < RANDOM_PIXELS - CALM_TAIL) && ((i / 100) % 3 != 2);
         if (idling_on && $urandom_range(0, 3) == 0) begin
            idle_cycles($urandom_range(1, 5));
         end
         px = ($urandom_range(0, 3) == 0) ? any_pixel() : typical_pixel();
         send_pixel(px);
      end
      start <= 1'b0;

      // drain the pipeline, then keep watching for stray strobes
      for (drain_cycles = 0;
           drain_cycles < DRAIN_LIMIT && rgb_board.rgb_expected.size() != 0;
           drain_cycles++) begin
         @(posedge clock);
      end
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (rgb_board.rgb_expected.size() != 0) begin
         rgb_board.report_mismatch($sformatf("%0d pixels never produced a result",
                                             rgb_board.rgb_expected.size()));
      end

      $display("covered %0d pixels (%0d gray), hue sectors hit 6'b%b",
               rgb_board.pixel_count, rgb_board.gray_count, rgb_board.sectors_seen);
      $display("%0d rgb results compared, %0d mismatches",
               rgb_board.checked_count, rgb_board.error_count);
      if (rgb_board.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("timeout waiting for the converter");
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/h2r_pkg.sv
sv/h2r_scale.sv
sv/hsv_to_rgb_pixel_converter_core.sv
test/tb_top.sv
